// ===== rtl/assert_macros.svh =====
// assertion macros shared by the rtl
// each use expands to one labeled concurrent assertion on clk, quiet in reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every edge outside reset
`define ASSERT_CHK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked outside reset
`define ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/alsm_pkg.sv =====
// package for the label slot mapper: widths, reset values, codes, state type
// no dependencies
`timescale 1ns / 1ps

package alsm_pkg;

	localparam int SLOTS_DEF  = 8;
	localparam int AGE_W      = 16;
	localparam int LABEL_W    = 31;
	localparam int FRAME_W    = 32;
	localparam int IDX_W      = 3;
	localparam int MASK_W     = 8;
	localparam int CFG_IDX_W  = 1;

	localparam logic [AGE_W-1:0] REUSE_AGE_RST = AGE_W'(500);
	localparam logic [AGE_W-1:0] SWEEP_AGE_RST = AGE_W'(33);

	localparam logic [CFG_IDX_W-1:0] REG_REUSE_AGE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SWEEP_AGE = 1'b1;

	localparam logic FUNC_MAP   = 1'b0;
	localparam logic FUNC_SWEEP = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_FINISH = 3'b100
	} state_t;

endpackage

// ===== rtl/aging_label_slot_mapper.sv =====
// label to slot mapper with per-slot age stamps, top level
// label and stamp live in one synchronous memory, valid bits in flops
// depends on alsm_pkg and assert_macros.svh
//
// usage:
//   command channel: start with func, label and frame_now is taken when busy
//   is low. func map looks the label up, refreshes its stamp on a hit, else
//   claims the lowest free or stale slot; func sweep returns disable_mask.
//   result: done is high for one cycle with slot_index, hit, assigned_new,
//   no_slot and disable_mask; the receiver cannot stall, nothing waits.
//   config: cfg_valid/cfg_ready write cfg_index 0 reuse_age, 1 sweep_age;
//   cfg_ready is always high; the user must write only while no item is in
//   flight, the block itself does not enforce it. timing: busy spans the scan,
//   one memory read per slot on one read port, and the finish state; done
//   strobes in the cycle after busy falls; start may be taken again in that same cycle.
//   reset: all slots free, ages back to 500 and 33, no memory clearing pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module aging_label_slot_mapper
	import alsm_pkg::*;
#(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 func,
	input  logic [LABEL_W-1:0]   label,
	input  logic [FRAME_W-1:0]   frame_now,
	output logic                 done,
	output logic [IDX_W-1:0]     slot_index,
	output logic                 hit,
	output logic                 assigned_new,
	output logic                 no_slot,
	output logic [MASK_W-1:0]    disable_mask,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [AGE_W-1:0]     cfg_data
);

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int DW = LABEL_W + FRAME_W;

	state_t state_q;

	logic [AGE_W-1:0]   reuse_age_q;
	logic [AGE_W-1:0]   sweep_age_q;
	logic [SLOTS-1:0]   valid_q;

	logic               func_q;
	logic [LABEL_W-1:0] label_q;
	logic [FRAME_W-1:0] now_q;
	logic [FRAME_W-1:0] thr_q;

	logic [CW-1:0]      cnt_q;
	logic               rd_en;
	logic [AW-1:0]      rd_idx_s1;
	logic               rd_vld_s1;
	logic [DW-1:0]      rd_data_s1;
	logic [DW-1:0]      mem [SLOTS];

	logic               hit_found_q;
	logic [AW-1:0]      hit_idx_q;
	logic               free_found_q;
	logic [AW-1:0]      free_idx_q;
	logic [MASK_W-1:0]  mask_q;

	logic               accept;
	logic [FRAME_W-1:0] age_sel;
	logic [FRAME_W-1:0] thr_c;
	logic [LABEL_W-1:0] ent_label;
	logic [FRAME_W-1:0] ent_stamp;
	logic               ent_valid;
	logic               ent_match;
	logic               ent_reuse;
	logic               last_rd;
	logic               we;
	logic [AW-1:0]      wr_idx;

	logic               done_q;
	logic [IDX_W-1:0]   slot_index_q;
	logic               hit_q;
	logic               new_q;
	logic               none_q;
	logic [MASK_W-1:0]  disable_mask_q;
	logic [2:0]         flags_c;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// saturating threshold now - age
	assign age_sel = (func == FUNC_SWEEP) ? FRAME_W'(sweep_age_q) : FRAME_W'(reuse_age_q);
	assign thr_c   = (frame_now > age_sel) ? (frame_now - age_sel) : '0;

	assign rd_en   = (state_q == ST_SCAN) && (cnt_q < CW'(SLOTS));
	assign last_rd = rd_vld_s1 && (rd_idx_s1 == AW'(SLOTS - 1));

	assign ent_label = rd_data_s1[DW-1:FRAME_W];
	assign ent_stamp = rd_data_s1[FRAME_W-1:0];
	assign ent_valid = valid_q[rd_idx_s1];
	assign ent_match = ent_valid && (ent_label == label_q);
	assign ent_reuse = !ent_valid || (ent_stamp < thr_q);

	assign we     = (state_q == ST_FINISH) && (func_q == FUNC_MAP)
	                && (hit_found_q || free_found_q);
	assign wr_idx = hit_found_q ? hit_idx_q : free_idx_q;

	// slot memory
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_idx] <= {label_q, now_q};
		end
		if (rd_en) begin
			rd_data_s1 <= mem[cnt_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reuse_age_q <= REUSE_AGE_RST;
			sweep_age_q <= SWEEP_AGE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_REUSE_AGE: reuse_age_q <= cfg_data;
				REG_SWEEP_AGE: sweep_age_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q  <= func;
			label_q <= label;
			now_q   <= frame_now;
			thr_q   <= thr_c;
		end
		rd_idx_s1 <= cnt_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			rd_vld_s1    <= 1'b0;
			valid_q      <= '0;
			hit_found_q  <= 1'b0;
			hit_idx_q    <= '0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			mask_q       <= '0;
		end else begin
			rd_vld_s1 <= rd_en;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q      <= ST_SCAN;
						cnt_q        <= '0;
						hit_found_q  <= 1'b0;
						free_found_q <= 1'b0;
						mask_q       <= '0;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (rd_vld_s1) begin
						if (ent_match && !hit_found_q) begin
							hit_found_q <= 1'b1;
							hit_idx_q   <= rd_idx_s1;
						end
						if (ent_reuse && !free_found_q) begin
							free_found_q <= 1'b1;
							free_idx_q   <= rd_idx_s1;
						end
						if (ent_reuse && (32'(rd_idx_s1) < MASK_W)) begin
							mask_q[3'(rd_idx_s1)] <= 1'b1;
						end
					end
					if (last_rd) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (we && !hit_found_q) begin
						valid_q[free_idx_q] <= 1'b1;
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FINISH);
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH) begin
			slot_index_q   <= '0;
			hit_q          <= 1'b0;
			new_q          <= 1'b0;
			none_q         <= 1'b0;
			disable_mask_q <= '0;
			if (func_q == FUNC_SWEEP) begin
				disable_mask_q <= mask_q;
			end else if (hit_found_q) begin
				slot_index_q <= IDX_W'(hit_idx_q);
				hit_q        <= 1'b1;
			end else if (free_found_q) begin
				slot_index_q <= IDX_W'(free_idx_q);
				new_q        <= 1'b1;
			end else begin
				none_q <= 1'b1;
			end
		end
	end

	assign done         = done_q;
	assign slot_index   = slot_index_q;
	assign hit          = hit_q;
	assign assigned_new = new_q;
	assign no_slot      = none_q;
	assign disable_mask = disable_mask_q;

	assign flags_c = {hit_q, new_q, none_q};

	`ASSERT_IMP(a_flags_excl, done_q, $onehot0(flags_c), "map result flags overlap")
	`ASSERT_NXT(a_start_busy, accept, busy, "accepted item did not raise busy")
	`ASSERT_NXT(a_finish_done, state_q == ST_FINISH, done_q, "finish without result strobe")
	`ASSERT_IMP(a_read_in_scan, rd_vld_s1, state_q == ST_SCAN, "read data outside scan")
	`ASSERT_IMP(a_no_write_idle, we, state_q == ST_FINISH, "slot write outside finish")

endmodule
